// File: rtl/oas_pkg.sv
// Field widths, operation codes and status codes of the ordered array store.
package oas_pkg;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND       = 3'd0,
    KIND_INSERT       = 3'd1,
    KIND_FIND         = 3'd2,
    KIND_REMOVE_FIRST = 3'd3,
    KIND_REMOVE_ALL   = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

endpackage

// File: rtl/ordered_array_store_top.sv
// Ordered array store: up to CAPACITY values in order with append, insert, find and remove.
//
// The block holds one transaction at a time and walks its entry memory, which has one
// write port and one registered read port, one entry per cycle. Append and insert at the
// end shift nothing, insert at a position p below the count shifts the entries from p
// up by one, and find, remove-first and remove-all read every stored entry; a rejected
// request (full store, bad position, unused kind) skips the walk. The input stalls
// while a transaction is in work; a finished result waits in its own output register, so
// the next transaction is accepted while the result is still stalled. count_o is the
// stored count modulo 128. No clearing pass follows reset.
module ordered_array_store_top #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [oas_pkg::KIND_W-1:0]   kind_i,
  input  logic [oas_pkg::POS_W-1:0]    position_i,
  input  logic [oas_pkg::VAL_W-1:0]    value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic [oas_pkg::STAT_W-1:0]   status_o,
  output logic [oas_pkg::COUNT_W-1:0]  count_o
);
  import oas_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      ri_q, ri_d;
  logic [CNT_W-1:0]      wi_q, wi_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      paddr_q, paddr_d;
  logic                  pend_q, pend_d;
  logic                  hit_q, hit_d;
  logic [ELEM_WIDTH-1:0] val_q, val_d;
  logic                  res_ok_q, res_ok_d;
  status_e               res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic                  ok_q, ok_d;
  status_e               out_st_q, out_st_d;
  logic [COUNT_W-1:0]    out_cnt_q, out_cnt_d;

  logic [ELEM_WIDTH-1:0] mem_q [CAPACITY];
  logic [ELEM_WIDTH-1:0] rdata_q;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;

  logic                  out_free;
  logic                  match;
  logic                  drop;
  logic [CNT_W-1:0]      ri_dec;

  assign out_free = !out_valid_q || !out_stall_i;
  assign match    = (rdata_q == val_q);
  // remove-all drops every match, remove-first only the earliest one
  assign drop     = match && ((kind_q == KIND_REMOVE_ALL) || !hit_q);
  assign ri_dec   = ri_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    count_d     = count_q;
    ri_d        = ri_q;
    wi_d        = wi_q;
    pos_d       = pos_q;
    paddr_d     = paddr_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    val_d       = val_q;
    res_ok_d    = res_ok_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = wi_q[IDX_W-1:0];
    mem_raddr   = ri_q[IDX_W-1:0];
    mem_wdata   = rdata_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          val_d  = ELEM_WIDTH'(value_i);
          ri_d   = '0;
          wi_d   = '0;
          pend_d = 1'b0;
          hit_d  = 1'b0;
          case (kind_i)
            KIND_APPEND: begin
              if (count_q == CAP_CNT) begin
                res_ok_d = 1'b0;
                res_st_d = STAT_FULL;
                state_d  = S_DONE;
              end else begin
                // append is an insert at the end with nothing to shift
                pos_d   = count_q;
                ri_d    = count_q;
                state_d = S_INS;
              end
            end
            KIND_INSERT: begin
              if (CMP_W'(position_i) > CMP_W'(count_q)) begin
                res_ok_d = 1'b0;
                res_st_d = STAT_RANGE;
                state_d  = S_DONE;
              end else if (count_q == CAP_CNT) begin
                res_ok_d = 1'b0;
                res_st_d = STAT_FULL;
                state_d  = S_DONE;
              end else begin
                pos_d   = CNT_W'(position_i);
                ri_d    = count_q;
                state_d = S_INS;
              end
            end
            KIND_FIND, KIND_REMOVE_FIRST, KIND_REMOVE_ALL: begin
              state_d = S_SCAN;
            end
            default: begin
              res_ok_d = 1'b0;
              res_st_d = STAT_DONE;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle, handle the registered data in the cycle after
        if (ri_q < count_q) begin
          mem_re = 1'b1;
          ri_d   = ri_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (match) begin
            hit_d = 1'b1;
          end
          // compact survivors down behind the read pointer
          if ((kind_q != KIND_FIND) && !drop) begin
            mem_we = 1'b1;
            wi_d   = wi_q + 1'b1;
          end
        end else if (ri_q == count_q) begin
          res_ok_d = hit_q;
          res_st_d = hit_q ? STAT_DONE : STAT_MISSING;
          if (hit_q && (kind_q != KIND_FIND)) begin
            count_d = wi_q;
          end
          state_d = S_DONE;
        end
      end

      S_INS: begin
        // shift up from the top: read entry i-1, write it to i next cycle
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_q[IDX_W-1:0];
          mem_wdata = rdata_q;
        end
        if (ri_q > pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = ri_dec[IDX_W-1:0];
          paddr_d   = ri_q;
          ri_d      = ri_dec;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q[IDX_W-1:0];
            mem_wdata = val_q;
            count_d   = count_q + 1'b1;
            res_ok_d  = 1'b1;
            res_st_d  = STAT_DONE;
            state_d   = S_DONE;
          end
        end
      end

      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d        = res_ok_q;
          out_st_d    = res_st_q;
          out_cnt_d   = COUNT_W'(count_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      ri_q        <= ri_d;
      wi_q        <= wi_d;
      pos_q       <= pos_d;
      paddr_q     <= paddr_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      val_q       <= val_d;
      res_ok_q    <= res_ok_d;
      res_st_q    <= res_st_d;
      ok_q        <= ok_d;
      out_st_q    <= out_st_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign status_o    = out_st_q;
  assign count_o     = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("stored count exceeds capacity");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (wi_q <= ri_q))
    else $error("compaction write pointer passed read pointer");

  a_shift_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS && pend_q) |-> (paddr_q > pos_q))
    else $error("insert shift writes at or below target position");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q))
    else $error("count changed outside a transaction");

  a_ok_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ok_o) |-> (status_o == STAT_DONE))
    else $error("successful result with failure status");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the ordered array store: directed table, then random phases.
module tb;
  import oas_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int MAX_SHOWN   = 50;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  localparam int GROW   = 0;
  localparam int SHRINK = 1;
  localparam int MIXED  = 2;

  typedef struct packed {
    logic               ok;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic [7:0]        reps;
    logic              pinned;
    result_t           want;
  } step_row_t;

  localparam result_t NO_RES = '{1'b0, STAT_DONE, 7'd0};

  localparam step_row_t SCRIPT [29] = '{
    '{KIND_FIND,         7'd0,   32'h0000_0000, 8'd1,  1'b1, '{1'b0, STAT_MISSING, 7'd0}},
    '{KIND_REMOVE_FIRST, 7'd0,   32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b0, STAT_MISSING, 7'd0}},
    '{KIND_REMOVE_ALL,   7'd0,   32'h0000_0000, 8'd1,  1'b1, '{1'b0, STAT_MISSING, 7'd0}},
    '{KIND_INSERT,       7'd1,   32'h0000_0001, 8'd1,  1'b1, '{1'b0, STAT_RANGE,   7'd0}},
    '{KIND_INSERT,       7'd127, 32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b0, STAT_RANGE,   7'd0}},
    '{KIND_UNUSED_LO,    7'd0,   32'h0000_0000, 8'd1,  1'b1, '{1'b0, STAT_DONE,    7'd0}},
    '{KIND_UNUSED_HI,    7'd127, 32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b0, STAT_DONE,    7'd0}},
    '{KIND_INSERT,       7'd0,   32'h0000_0000, 8'd1,  1'b1, '{1'b1, STAT_DONE,    7'd1}},
    '{KIND_APPEND,       7'd127, 32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b1, STAT_DONE,    7'd2}},
    '{KIND_APPEND,       7'd0,   32'h0000_0000, 8'd1,  1'b0, NO_RES},
    '{KIND_INSERT,       7'd3,   32'hA5A5_A5A5, 8'd1,  1'b0, NO_RES},
    '{KIND_INSERT,       7'd1,   32'h5A5A_5A5A, 8'd1,  1'b0, NO_RES},
    '{KIND_INSERT,       7'd6,   32'h0000_0009, 8'd1,  1'b1, '{1'b0, STAT_RANGE,   7'd5}},
    '{KIND_FIND,         7'd0,   32'hFFFF_FFFF, 8'd1,  1'b0, NO_RES},
    '{KIND_FIND,         7'd0,   32'h1234_5678, 8'd1,  1'b1, '{1'b0, STAT_MISSING, 7'd5}},
    '{KIND_REMOVE_FIRST, 7'd0,   32'h0000_0000, 8'd1,  1'b0, NO_RES},
    '{KIND_REMOVE_ALL,   7'd0,   32'hA5A5_A5A5, 8'd1,  1'b0, NO_RES},
    '{KIND_APPEND,       7'd0,   32'h0000_0000, 8'd1,  1'b0, NO_RES},
    '{KIND_REMOVE_ALL,   7'd0,   32'h0000_0000, 8'd1,  1'b0, NO_RES},
    '{KIND_REMOVE_FIRST, 7'd0,   32'h5A5A_5A5A, 8'd1,  1'b0, NO_RES},
    '{KIND_APPEND,       7'd0,   32'h0000_0077, 8'd63, 1'b0, NO_RES},
    '{KIND_APPEND,       7'd0,   32'h0000_0001, 8'd1,  1'b1, '{1'b0, STAT_FULL,    7'd64}},
    '{KIND_INSERT,       7'd64,  32'h0000_0001, 8'd1,  1'b1, '{1'b0, STAT_FULL,    7'd64}},
    '{KIND_INSERT,       7'd65,  32'h0000_0001, 8'd1,  1'b1, '{1'b0, STAT_RANGE,   7'd64}},
    '{KIND_INSERT,       7'd0,   32'h0000_0002, 8'd1,  1'b1, '{1'b0, STAT_FULL,    7'd64}},
    '{KIND_REMOVE_FIRST, 7'd0,   32'hFFFF_FFFF, 8'd1,  1'b0, NO_RES},
    '{KIND_INSERT,       7'd0,   32'h0000_0003, 8'd1,  1'b0, NO_RES},
    '{KIND_REMOVE_ALL,   7'd0,   32'h0000_0077, 8'd1,  1'b0, NO_RES},
    '{KIND_REMOVE_ALL,   7'd0,   32'h0000_0003, 8'd1,  1'b0, NO_RES}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i;
  logic [POS_W-1:0]   position_i;
  logic [VAL_W-1:0]   value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               ok_o;
  logic [STAT_W-1:0]  status_o;
  logic [COUNT_W-1:0] count_o;

  // Stimulus side tags for the transaction on the input port
  logic               row_pinned;
  result_t            row_want;
  bit                 out_jitter = 1'b0;
  int                 stall_left = 0;

  // Predictor state
  logic [VAL_W-1:0]   held_vals [CAPACITY];
  int                 held_cnt = 0;
  int                 fill_level = 0;
  result_t            pending_results [$];
  result_t            want, predicted;

  int                 err_count = 0;
  int                 cycle_cnt = 0;
  int                 n_accepted = 0;
  int                 n_checked = 0;
  int                 n_full = 0;
  int                 n_range = 0;
  int                 n_missing = 0;

  ordered_array_store_top #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(VAL_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .position_i (position_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
  endtask

  // Apply one operation to the held array and return the result it produces
  function automatic result_t next_store_result(input logic [KIND_W-1:0] k,
                                                input logic [POS_W-1:0]  p,
                                                input logic [VAL_W-1:0]  v);
    result_t r;
    int      hit;
    int      keep;
    r.ok     = 1'b0;
    r.status = STAT_DONE;
    hit      = -1;
    for (int i = 0; i < held_cnt; i++) begin
      if (hit < 0 && held_vals[i] == v) hit = i;
    end
    case (k)
      KIND_APPEND: begin
        if (held_cnt >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          held_vals[held_cnt] = v;
          held_cnt++;
          r.ok = 1'b1;
        end
      end
      KIND_INSERT: begin
        // position is checked before fullness
        if (int'(p) > held_cnt) begin
          r.status = STAT_RANGE;
        end else if (held_cnt >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = held_cnt; i > int'(p); i--) held_vals[i] = held_vals[i-1];
          held_vals[p] = v;
          held_cnt++;
          r.ok = 1'b1;
        end
      end
      KIND_FIND: begin
        if (hit >= 0) r.ok = 1'b1;
        else r.status = STAT_MISSING;
      end
      KIND_REMOVE_FIRST: begin
        if (hit < 0) begin
          r.status = STAT_MISSING;
        end else begin
          for (int i = hit; i + 1 < held_cnt; i++) held_vals[i] = held_vals[i+1];
          held_cnt--;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE_ALL: begin
        if (hit < 0) begin
          r.status = STAT_MISSING;
        end else begin
          keep = 0;
          for (int i = 0; i < held_cnt; i++) begin
            if (held_vals[i] != v) begin
              held_vals[keep] = held_vals[i];
              keep++;
            end
          end
          held_cnt = keep;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(held_cnt);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stall: random bursts, off while out_jitter is clear
  always @(posedge clk_i) begin
    if (!out_jitter) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check results first, then predict the transaction taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (ok_o !== want.ok)
            note_mismatch($sformatf("ok %b, want %b", ok_o, want.ok));
          if (status_o !== want.status)
            note_mismatch($sformatf("status %0d, want %s", status_o, want.status.name()));
          if (count_o !== want.count)
            note_mismatch($sformatf("count %0d, want %0d", count_o, want.count));
          case (want.status)
            STAT_FULL:    n_full++;
            STAT_RANGE:   n_range++;
            STAT_MISSING: n_missing++;
            default: ;
          endcase
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        predicted = next_store_result(kind_i, position_i, value_i);
        pending_results.insert(pending_results.size(), row_pinned ? row_want : predicted);
        fill_level <= held_cnt;
        n_accepted++;
      end
    end
  end

  bit in_jitter = 1'b1;

  // Present one transaction, optionally after an idle burst, and hold it until taken
  task automatic send_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                         input logic [VAL_W-1:0] v, input logic pin, input result_t w);
    int gap;
    gap = (in_jitter && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    position_i <= p;
    value_i    <= v;
    row_pinned <= pin;
    row_want   <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  initial begin : stimulus
    int                unsigned cut [3][5];
    logic [VAL_W-1:0]  pool [8];
    logic [KIND_W-1:0] k;
    logic [POS_W-1:0]  p;
    logic [VAL_W-1:0]  v;
    int                mode;
    int                r;

    cut = '{'{35, 70, 80, 90, 95}, '{12, 24, 40, 75, 92}, '{22, 44, 62, 80, 93}};
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_APPEND;
    position_i  <= '0;
    value_i     <= '0;
    row_pinned  <= 1'b0;
    row_want    <= NO_RES;
    out_stall_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni     <= 1'b1;
    out_jitter <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[i]) begin
      for (int n = 0; n < SCRIPT[i].reps; n++)
        send_op(SCRIPT[i].kind, SCRIPT[i].pos, SCRIPT[i].val, SCRIPT[i].pinned,
                SCRIPT[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      mode       = (ph % 3 == 0) ? GROW : (ph % 3 == 1) ? SHRINK : MIXED;
      // one stretch of each side runs without idling; the last phases run flat out
      in_jitter  = (ph != 3) && (ph < N_PHASES - 2);
      out_jitter <= (ph != 5) && (ph < N_PHASES - 2);
      // a small value pool per phase keeps finds and removals hitting
      foreach (pool[j]) pool[j] = ($urandom_range(0, 3) == 0) ? {VAL_W{j[0]}} : $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < cut[mode][0])      k = KIND_APPEND;
        else if (r < cut[mode][1]) k = KIND_INSERT;
        else if (r < cut[mode][2]) k = KIND_FIND;
        else if (r < cut[mode][3]) k = KIND_REMOVE_FIRST;
        else if (r < cut[mode][4]) k = KIND_REMOVE_ALL;
        else k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        v = ($urandom_range(0, 4) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
        r = $urandom_range(0, 99);
        if (k != KIND_INSERT || r >= 90) p = POS_W'($urandom_range(0, 127));
        else if (r < 75)                 p = POS_W'($urandom_range(0, fill_level));
        else                             p = POS_W'(fill_level + $urandom_range(1, 3));
        send_op(k, p, v, 1'b0, NO_RES);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("Covered %0d transactions and %0d checked results", n_accepted, n_checked);
    $display("Rejections seen: %0d full, %0d bad position, %0d value absent",
             n_full, n_range, n_missing);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
